FILE: rtl/core/ifns_pkg.sv
package ifns_pkg;

  // default size limits
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // smallest frame side that the filter accepts
  localparam int unsigned MIN_SIZE = 5;
  // filtered pixels keep this distance from every edge
  localparam int unsigned EDGE_GAP = 2;

  // register field widths
  localparam int unsigned FW_BITS   = 11;
  localparam int unsigned FH_BITS   = 13;
  localparam int unsigned PIX_BITS  = 8;
  localparam int unsigned ADDR_BITS = 4;
  localparam int unsigned DATA_BITS = 32;

  // register reset values
  localparam logic [FW_BITS-1:0]  FW_RESET   = FW_BITS'(320);
  localparam logic [FH_BITS-1:0]  FH_RESET   = FH_BITS'(200);
  localparam logic [PIX_BITS-1:0] BIAS_RESET = PIX_BITS'(2);

  // register index codes (byte address / 4)
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BIAS         = 2'd2;

  // input kind codes
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // output buffer
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR   = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT   = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic                fend;
    logic [PIX_BITS-1:0] pixel;
  } out_word_t;

endpackage

FILE: rtl/core/inplace_four_neighbour_smoother_unit.sv
// Four-neighbour smoothing filter for 8-bit frames streamed in raster order. Each pixel at
// least two rows and two columns from every edge becomes (new left + old right + new above
// + old below) / 4 + bias, wrapped to 8 bits; all other pixels pass unchanged. Output trails
// the input by one line: the first frame_width pixels of a frame are only stored, and the
// last line of a frame leaves while the next frame's first line arrives, or on drain words
// (tuser = 1). Throughput is one word per clock in steady state while the sink keeps up;
// each word passes the datapath (accept and synchronous read of the two line memories,
// then compute and write-back) and then sits in a four-entry output buffer. s_axis_tready drops
// while the buffer and the compute stage hold three results between them, so a stalled
// sink stops input with at most three results waiting. After reset both line memories are
// cleared, one entry per cycle, over all MAX_WIDTH entries; s_axis_tready stays low meanwhile,
// while register writes are taken as usual. Registers: 0x0 frame_width (clamped to
// 5..MAX_WIDTH), 0x4 frame_height (clamped to 5..MAX_HEIGHT), 0x8 bias; write them only
// while no word is in flight.
module inplace_four_neighbour_smoother_unit #(
  parameter int unsigned MAX_WIDTH  = ifns_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = ifns_pkg::MAX_HEIGHT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // stream input
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [ifns_pkg::PIX_BITS-1:0]      s_axis_tdata,   // [7:0] pixel_in
  input  logic                               s_axis_tuser,   // [0] kind
  // stream output
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [ifns_pkg::PIX_BITS-1:0]      m_axis_tdata,   // [7:0] pixel_out
  output logic                               m_axis_tlast,   // frame_end
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ifns_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [ifns_pkg::DATA_BITS-1:0]     pwdata,
  output logic [ifns_pkg::DATA_BITS-1:0]     prdata,
  output logic                               pready
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);       // column / memory address
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);   // width value, fill count
  localparam int unsigned RW = $clog2(MAX_HEIGHT);      // row
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);  // height value
  localparam int unsigned PB = ifns_pkg::PIX_BITS;

  // control carried from the accept stage to the compute stage
  typedef struct packed {
    logic          emit;     // word produces a result
    logic          filt;     // interior pixel, take the average
    logic          fend;     // last pixel of the frame
    logic          old_we;   // store input pixel in the old line
    logic [AW-1:0] old_wa;
    logic [AW-1:0] col;      // output column, new line write address
    logic [PB-1:0] pix;
  } stage_t;

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  logic [ifns_pkg::FW_BITS-1:0] fw_q;
  logic [ifns_pkg::FH_BITS-1:0] fh_q;
  logic [PB-1:0]                bias_q;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= ifns_pkg::FW_RESET;
      fh_q   <= ifns_pkg::FH_RESET;
      bias_q <= ifns_pkg::BIAS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        ifns_pkg::REG_FRAME_WIDTH:  fw_q   <= pwdata[ifns_pkg::FW_BITS-1:0];
        ifns_pkg::REG_FRAME_HEIGHT: fh_q   <= pwdata[ifns_pkg::FH_BITS-1:0];
        ifns_pkg::REG_BIAS:         bias_q <= pwdata[PB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ifns_pkg::REG_FRAME_WIDTH:  prdata = ifns_pkg::DATA_BITS'(fw_q);
      ifns_pkg::REG_FRAME_HEIGHT: prdata = ifns_pkg::DATA_BITS'(fh_q);
      ifns_pkg::REG_BIAS:         prdata = ifns_pkg::DATA_BITS'(bias_q);
      default:                    prdata = '0;
    endcase
  end

  // clamped frame size and the bounds derived from it
  logic [WW-1:0] w, wm1, wm3;
  logic [HW-1:0] h, hm1, hm3;

  always_comb begin
    if (32'(fw_q) < ifns_pkg::MIN_SIZE)  w = WW'(ifns_pkg::MIN_SIZE);
    else if (32'(fw_q) > MAX_WIDTH)      w = WW'(MAX_WIDTH);
    else                                 w = WW'(fw_q);
    if (32'(fh_q) < ifns_pkg::MIN_SIZE)  h = HW'(ifns_pkg::MIN_SIZE);
    else if (32'(fh_q) > MAX_HEIGHT)     h = HW'(MAX_HEIGHT);
    else                                 h = HW'(fh_q);
  end

  // bounds stay positive since both sides are at least five
  assign wm1 = w - WW'(1);
  assign wm3 = w - WW'(ifns_pkg::EDGE_GAP + 1);
  assign hm1 = h - HW'(1);
  assign hm3 = h - HW'(ifns_pkg::EDGE_GAP + 1);

  // ---------------------------------------------------------------------------
  // clearing pass after reset
  // ---------------------------------------------------------------------------
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(MAX_WIDTH - 1)) clr_busy_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // accept stage: position bookkeeping and memory read issue
  // ---------------------------------------------------------------------------
  logic [AW-1:0]             col_q, col_d;
  logic [RW-1:0]             row_q, row_d;
  logic [WW-1:0]             fill_q, fill_d;
  stage_t                    s1_q, s1_d;
  logic [ifns_pkg::OUT_CNT-1:0] out_cnt_q;

  logic          accept, drain;
  logic          last_line, filling, eol, interior;
  logic [RW-1:0] row_inc;
  logic [AW-1:0] rd_right;

  // room for the word in compute, the word taken now and one more, so a full-rate stream never waits
  assign s_axis_tready = !clr_busy_q &&
                         ((out_cnt_q + ifns_pkg::OUT_CNT'(s1_q.emit))
                          <= ifns_pkg::OUT_CNT'(ifns_pkg::OUT_DEPTH - 2));
  assign accept = s_axis_tvalid & s_axis_tready;
  assign drain  = (s_axis_tuser == ifns_pkg::KIND_DRAIN);

  assign last_line = HW'(row_q) >= hm1;
  assign filling   = fill_q < w;
  assign eol       = WW'(col_q) >= wm1;
  assign interior  = (HW'(row_q) >= HW'(ifns_pkg::EDGE_GAP)) && (HW'(row_q) <= hm3) &&
                     (WW'(col_q) >= WW'(ifns_pkg::EDGE_GAP)) && (WW'(col_q) <= wm3);
  assign row_inc   = row_q + RW'(1);
  // right neighbour; at the top column it is never used
  assign rd_right  = (col_q == AW'(MAX_WIDTH - 1)) ? col_q : col_q + AW'(1);

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    fill_d    = fill_q;
    s1_d      = '0;
    s1_d.col  = col_q;
    s1_d.pix  = s_axis_tdata;
    if (accept) begin
      if (last_line) begin
        // bottom border row leaves unchanged, input refills the old line
        s1_d.emit = 1'b1;
        if (!drain && filling) begin
          s1_d.old_we = 1'b1;
          s1_d.old_wa = fill_q[AW-1:0];
          fill_d      = fill_q + WW'(1);
        end
        if (eol) begin
          s1_d.fend = 1'b1;
          col_d     = '0;
          row_d     = '0;
        end else begin
          col_d = col_q + AW'(1);
        end
      end else if (filling) begin
        if (!drain) begin
          s1_d.old_we = 1'b1;
          s1_d.old_wa = fill_q[AW-1:0];
          fill_d      = fill_q + WW'(1);
        end
      end else if (!drain) begin
        s1_d.emit   = 1'b1;
        s1_d.filt   = interior;
        s1_d.old_we = 1'b1;
        s1_d.old_wa = col_q;
        if (eol) begin
          col_d = '0;
          row_d = row_inc;
          if (HW'(row_inc) >= hm1) fill_d = '0;
        end else begin
          col_d = col_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      fill_q <= '0;
      s1_q   <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      fill_q <= fill_d;
      s1_q   <= s1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // line memories
  // the accept stage reads columns c and c+1 while the compute stage writes
  // the word before it; that write lands in the old line at the same edge as
  // the read, so a matching address takes the pixel from the compute stage
  // (happens when the frame size changes mid-frame); the new line write never
  // meets the read of the word behind it
  // ---------------------------------------------------------------------------
  logic [PB-1:0] old_line_q [MAX_WIDTH];
  logic [PB-1:0] new_line_q [MAX_WIDTH];
  logic [PB-1:0] old_cur_q, old_right_q, new_above_q;
  logic          fwd_cur_q, fwd_right_q;
  logic [PB-1:0] fwd_pix_q;
  logic [PB-1:0] old_cur, old_right;

  logic          old_we, new_we;
  logic [AW-1:0] old_wa, new_wa;
  logic [PB-1:0] old_wd, new_wd;
  logic [PB-1:0] res;

  assign old_we = clr_busy_q | s1_q.old_we;
  assign old_wa = clr_busy_q ? clr_addr_q : s1_q.old_wa;
  assign old_wd = clr_busy_q ? '0 : s1_q.pix;
  assign new_we = clr_busy_q | s1_q.emit;
  assign new_wa = clr_busy_q ? clr_addr_q : s1_q.col;
  assign new_wd = clr_busy_q ? '0 : res;

  always_ff @(posedge clk_i) begin
    if (old_we) old_line_q[old_wa] <= old_wd;
    old_cur_q   <= old_line_q[col_q];
    old_right_q <= old_line_q[rd_right];
    fwd_cur_q   <= s1_q.old_we && (s1_q.old_wa == col_q);
    fwd_right_q <= s1_q.old_we && (s1_q.old_wa == rd_right);
    fwd_pix_q   <= s1_q.pix;
  end

  assign old_cur   = fwd_cur_q ? fwd_pix_q : old_cur_q;
  assign old_right = fwd_right_q ? fwd_pix_q : old_right_q;

  always_ff @(posedge clk_i) begin
    if (new_we) new_line_q[new_wa] <= new_wd;
    new_above_q <= new_line_q[col_q];
  end

  // ---------------------------------------------------------------------------
  // compute stage
  // ---------------------------------------------------------------------------
  logic [PB-1:0]   left_new_q;
  logic [PB+1:0]   sum;

  // new left + old right + new above + old below
  assign sum = (PB+2)'(left_new_q) + (PB+2)'(old_right) +
               (PB+2)'(new_above_q) + (PB+2)'(s1_q.pix);
  assign res = s1_q.filt ? (sum[PB+1:2] + bias_q) : old_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_new_q <= '0;
    end else if (s1_q.emit) begin
      left_new_q <= res;
    end
  end

  // ---------------------------------------------------------------------------
  // output buffer
  // ---------------------------------------------------------------------------
  ifns_pkg::out_word_t          out_buf_q [ifns_pkg::OUT_DEPTH];
  logic [ifns_pkg::OUT_PTR-1:0] wr_ptr_q, rd_ptr_q;
  logic                         pop;
  ifns_pkg::out_word_t          out_word;

  assign pop           = m_axis_tvalid & m_axis_tready;
  assign m_axis_tvalid = (out_cnt_q != '0);
  assign out_word      = out_buf_q[rd_ptr_q];
  assign m_axis_tdata  = out_word.pixel;
  assign m_axis_tlast  = out_word.fend;

  always_ff @(posedge clk_i) begin
    if (s1_q.emit) begin
      out_buf_q[wr_ptr_q].pixel <= res;
      out_buf_q[wr_ptr_q].fend  <= s1_q.fend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (s1_q.emit) wr_ptr_q <= wr_ptr_q + ifns_pkg::OUT_PTR'(1);
      if (pop)       rd_ptr_q <= rd_ptr_q + ifns_pkg::OUT_PTR'(1);
      out_cnt_q <= out_cnt_q + ifns_pkg::OUT_CNT'(s1_q.emit) - ifns_pkg::OUT_CNT'(pop);
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a result leaving compute always finds a free buffer entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q.emit |-> (out_cnt_q < ifns_pkg::OUT_CNT'(ifns_pkg::OUT_DEPTH)))
    else $error("output buffer overflow");

  // no word enters while the line memories are being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s_axis_tready)
    else $error("word accepted during clearing pass");

  // clearing owns the write ports, so nothing may be in compute then
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (!s1_q.emit && !s1_q.old_we))
    else $error("compute stage active during clearing pass");

  // output column never runs past the memory depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (32'(col_q) < MAX_WIDTH))
    else $error("output column out of range");

endmodule
